FILE: src/local_binary_pattern_3x3_unit_macros.svh
// ----------------------------------------------------------------------------
// LBP 3x3 assertion macros
// Concurrent assertion shorthands, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef LOCAL_BINARY_PATTERN_3X3_UNIT_MACROS_SVH
`define LOCAL_BINARY_PATTERN_3X3_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LBP3_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lbp3 assertion failed");

// Next-cycle implication.
`define LBP3_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lbp3 assertion failed");

`else

`define LBP3_ASSERT_IMP(label, ante, cons)
`define LBP3_ASSERT_NXT(label, ante, cons)

`endif

`endif

FILE: src/lbp3_pkg.sv
// ----------------------------------------------------------------------------
// LBP 3x3 package
// Shared constants, register and command codes, result item type.
// ----------------------------------------------------------------------------
package lbp3_pkg;

  localparam int unsigned CODE_BITS  = 8;
  localparam int unsigned DIM_BITS   = 13;
  localparam int unsigned ROW_BITS   = 12;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam int unsigned TBL_DEPTH  = 256;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_BITS = 2;
  localparam int unsigned FIFO_CNT_BITS = 3;

  localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 13'd480;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FRAME_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT   = 2'd1,
    REG_UNIFORM_ENABLE = 2'd2,
    REG_SIGNED_COMPARE = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_TABLE = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [CODE_BITS-1:0] code;
    logic                 frame_last;
  } out_item_t;

endpackage

FILE: src/lbp3_channels.sv
// ----------------------------------------------------------------------------
// LBP 3x3 channel interfaces
// Valid/ready channels for input items and result codes.
// ----------------------------------------------------------------------------
interface lbp3_in_if #(
  parameter int unsigned PIXEL_BITS = 8
);
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [PIXEL_BITS-1:0] pixel;
  logic [7:0]            table_index;
  logic [7:0]            table_value;

  modport source (output valid, cmd, pixel, table_index, table_value, input ready);
  modport sink   (input valid, cmd, pixel, table_index, table_value, output ready);
endinterface

interface lbp3_out_if;
  logic                            valid;
  logic                            ready;
  logic [lbp3_pkg::CODE_BITS-1:0]  code;
  logic                            frame_last;

  modport source (output valid, code, frame_last, input ready);
  modport sink   (input valid, code, frame_last, output ready);
endinterface

FILE: src/local_binary_pattern_3x3_unit.sv
// ----------------------------------------------------------------------------
// Local binary pattern 3x3 unit
// LBP(8,1) over a raster pixel stream with optional uniform-code mapping.
// ----------------------------------------------------------------------------
// Takes one transaction per clock, pixels (cmd 0) and mapping table writes
// (cmd 1) alike, and keeps that rate for as long as the result consumer
// keeps up. Each interior pixel yields one 8-bit code for the transaction
// that brings the pixel below-right of the centre, through the line store
// read and then the mapping table read. The two line stores live in one
// RAM of 2*PIXEL_BITS x MAX_WIDTH that is read at the accept edge and
// written back the cycle after; consecutive pixels always hit different
// columns, so no forwarding is needed. Results drain through a four-entry
// queue; input ready is driven from a credit count of codes in flight,
// never from the consumer's ready. Line stores and table come out of reset
// unwritten (no clearing pass): load the table before enabling uniform mode.
// Registers are to be written only while the unit is idle; it does not enforce this.
// ----------------------------------------------------------------------------
`include "local_binary_pattern_3x3_unit_macros.svh"

module local_binary_pattern_3x3_unit #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lbp3_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [lbp3_pkg::DIM_BITS-1:0]     cfg_data_i,
  lbp3_in_if.sink                           in_i,
  lbp3_out_if.source                        out_o
);

  localparam int unsigned COL_BITS = $clog2(MAX_WIDTH);
  // wide enough for the width register and for MAX_WIDTH itself
  localparam int unsigned CMP_BITS =
    ($clog2(MAX_WIDTH + 1) > lbp3_pkg::DIM_BITS) ? $clog2(MAX_WIDTH + 1)
                                                 : lbp3_pkg::DIM_BITS;
  localparam int unsigned ROW_BITS = lbp3_pkg::ROW_BITS;
  localparam int unsigned DB = lbp3_pkg::DIM_BITS;

  // --- configuration registers
  logic [DB-1:0] frame_width_q, frame_height_q;
  logic          uniform_q, signed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= lbp3_pkg::WIDTH_RESET;
      frame_height_q <= lbp3_pkg::HEIGHT_RESET;
      uniform_q      <= 1'b0;
      signed_q       <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (lbp3_pkg::cfg_reg_e'(cfg_index_i))
        lbp3_pkg::REG_FRAME_WIDTH:    frame_width_q  <= cfg_data_i;
        lbp3_pkg::REG_FRAME_HEIGHT:   frame_height_q <= cfg_data_i;
        lbp3_pkg::REG_UNIFORM_ENABLE: uniform_q      <= cfg_data_i[0];
        lbp3_pkg::REG_SIGNED_COMPARE: signed_q       <= cfg_data_i[0];
      endcase
    end
  end

  // --- geometry: last column and last row after saturation
  logic [CMP_BITS-1:0] fw_ext, col_last_w;
  logic [DB-1:0]       row_last_w;

  assign fw_ext = CMP_BITS'(frame_width_q);

  always_comb begin
    if (fw_ext < CMP_BITS'(3)) begin
      col_last_w = CMP_BITS'(2);
    end else if (fw_ext > CMP_BITS'(MAX_WIDTH)) begin
      col_last_w = CMP_BITS'(MAX_WIDTH - 1);
    end else begin
      col_last_w = fw_ext - 1'b1;
    end
    if (frame_height_q < DB'(3)) begin
      row_last_w = DB'(2);
    end else if (frame_height_q > DB'(lbp3_pkg::MAX_HEIGHT)) begin
      row_last_w = DB'(lbp3_pkg::MAX_HEIGHT - 1);
    end else begin
      row_last_w = frame_height_q - 1'b1;
    end
  end

  // --- position counters, stepped on each pixel transaction
  logic [COL_BITS-1:0] col_q, col_d, col_use;
  logic [ROW_BITS-1:0] row_q, row_d, row_use;
  logic                last_col, last_row, emit;
  logic                in_acc, pix_acc, tbl_acc;

  assign in_acc  = in_i.valid && in_i.ready;
  assign pix_acc = in_acc && (lbp3_pkg::cmd_e'(in_i.cmd) == lbp3_pkg::CMD_PIXEL);
  assign tbl_acc = in_acc && (lbp3_pkg::cmd_e'(in_i.cmd) == lbp3_pkg::CMD_TABLE);

  always_comb begin
    last_col = CMP_BITS'(col_q) >= col_last_w;
    last_row = DB'(row_q) >= row_last_w;
    col_use  = last_col ? col_last_w[COL_BITS-1:0] : col_q;
    row_use  = last_row ? row_last_w[ROW_BITS-1:0] : row_q;
    emit     = (row_use >= ROW_BITS'(2)) && (col_use >= COL_BITS'(2));
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_use + 1'b1;
    end else begin
      col_d = col_use + 1'b1;
      row_d = row_use;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (pix_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // --- stage 1: line store data arrives, code is formed, write-back
  logic                  s1_valid_q, s1_emit_q, s1_last_q;
  logic [COL_BITS-1:0]   s1_col_q;
  logic [PIXEL_BITS-1:0] s1_low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
      s1_last_q  <= 1'b0;
    end else begin
      s1_valid_q <= pix_acc;
      s1_emit_q  <= pix_acc && emit;
      s1_last_q  <= last_col && last_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      s1_col_q <= col_use;
      s1_low_q <= in_i.pixel;
    end
  end

  // Line RAM entry: {upper row, middle row}
  logic [2*PIXEL_BITS-1:0]        line_rdata;
  logic [PIXEL_BITS-1:0]          up_pix, mid_pix;
  logic [lbp3_pkg::CODE_BITS-1:0] raw_code;

  assign up_pix  = line_rdata[2*PIXEL_BITS-1:PIXEL_BITS];
  assign mid_pix = line_rdata[PIXEL_BITS-1:0];

  lbp3_ram #(
    .WIDTH (2 * PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_col_q),
    .wdata_i ({mid_pix, s1_low_q}),
    .re_i    (pix_acc),
    .raddr_i (col_use),
    .rdata_o (line_rdata)
  );

  lbp3_window #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (s1_valid_q),
    .signed_i (signed_q),
    .up_i     (up_pix),
    .mid_i    (mid_pix),
    .low_i    (s1_low_q),
    .code_o   (raw_code)
  );

  // --- stage 2: mapping table read
  logic                           s2_valid_q, s2_last_q;
  logic [lbp3_pkg::CODE_BITS-1:0] s2_code_q, tbl_rdata;

  lbp3_ram #(
    .WIDTH (lbp3_pkg::CODE_BITS),
    .DEPTH (lbp3_pkg::TBL_DEPTH)
  ) u_table_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_acc),
    .waddr_i (in_i.table_index),
    .wdata_i (in_i.table_value),
    .re_i    (s1_emit_q),
    .raddr_i (raw_code),
    .rdata_o (tbl_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_emit_q) begin
      s2_code_q <= raw_code;
      s2_last_q <= s1_last_q;
    end
  end

  // --- result queue and credit
  lbp3_pkg::out_item_t push_item, head_item;
  logic                fifo_valid, out_acc;
  logic [lbp3_pkg::FIFO_CNT_BITS-1:0] pending_q;

  assign push_item.code       = uniform_q ? tbl_rdata : s2_code_q;
  assign push_item.frame_last = s2_last_q;

  lbp3_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s2_valid_q),
    .push_data_i (push_item),
    .pop_i       (out_o.ready),
    .valid_o     (fifo_valid),
    .data_o      (head_item)
  );

  assign out_o.valid      = fifo_valid;
  assign out_o.code       = head_item.code;
  assign out_o.frame_last = head_item.frame_last;
  assign out_acc          = out_o.valid && out_o.ready;

  // codes in the pipeline plus codes queued
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      unique case ({pix_acc && emit, out_acc})
        2'b10:   pending_q <= pending_q + 1'b1;
        2'b01:   pending_q <= pending_q - 1'b1;
        default: pending_q <= pending_q;
      endcase
    end
  end

  assign in_i.ready =
    pending_q < lbp3_pkg::FIFO_CNT_BITS'(lbp3_pkg::FIFO_DEPTH);

  // Write-back and next read never target the same column.
  `LBP3_ASSERT_IMP(a_line_no_collision,
    s1_valid_q && pix_acc, s1_col_q != col_use)
  // Credit never exceeds queue depth.
  `LBP3_ASSERT_IMP(a_credit_bound,
    1'b1, pending_q <= lbp3_pkg::FIFO_CNT_BITS'(lbp3_pkg::FIFO_DEPTH))
  // No result shown without an outstanding credit.
  `LBP3_ASSERT_IMP(a_no_orphan_result, pending_q == '0, !out_o.valid)
  // An emitting pixel reaches the table read stage next cycle.
  `LBP3_ASSERT_NXT(a_emit_tracks, pix_acc && emit, s1_emit_q && s1_valid_q)

endmodule

FILE: src/lbp3_ram.sv
// ----------------------------------------------------------------------------
// LBP 3x3 generic RAM
// One write port, one read port, registered read data (read-first).
// ----------------------------------------------------------------------------
module lbp3_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/lbp3_window.sv
// ----------------------------------------------------------------------------
// LBP 3x3 window
// Two stored columns plus the incoming column; eight compares to a code.
// ----------------------------------------------------------------------------
module lbp3_window #(
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           shift_i,
  input  logic                           signed_i,
  input  logic [PIXEL_BITS-1:0]          up_i,
  input  logic [PIXEL_BITS-1:0]          mid_i,
  input  logic [PIXEL_BITS-1:0]          low_i,
  output logic [lbp3_pkg::CODE_BITS-1:0] code_o
);

  // [0..2] column c-2 (top, middle, bottom), [3..5] column c-1
  logic [PIXEL_BITS-1:0] win_q [6];
  logic [PIXEL_BITS-1:0] flip;
  logic [PIXEL_BITS-1:0] k_c;

  // Signed order equals unsigned order with the sign bit inverted.
  assign flip = {signed_i, {(PIXEL_BITS-1){1'b0}}};
  assign k_c  = win_q[4] ^ flip;

  always_comb begin
    code_o[7] = (win_q[0] ^ flip) >= k_c;
    code_o[6] = (win_q[3] ^ flip) >= k_c;
    code_o[5] = (up_i     ^ flip) >= k_c;
    code_o[4] = (mid_i    ^ flip) >= k_c;
    code_o[3] = (low_i    ^ flip) >= k_c;
    code_o[2] = (win_q[5] ^ flip) >= k_c;
    code_o[1] = (win_q[2] ^ flip) >= k_c;
    code_o[0] = (win_q[1] ^ flip) >= k_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (shift_i) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= up_i;
      win_q[4] <= mid_i;
      win_q[5] <= low_i;
    end
  end

endmodule

FILE: src/lbp3_out_fifo.sv
// ----------------------------------------------------------------------------
// LBP 3x3 output FIFO
// Small result queue decoupling the pipeline from the consumer.
// ----------------------------------------------------------------------------
`include "local_binary_pattern_3x3_unit_macros.svh"

module lbp3_out_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lbp3_pkg::out_item_t push_data_i,
  input  logic                pop_i,
  output logic                valid_o,
  output lbp3_pkg::out_item_t data_o
);

  lbp3_pkg::out_item_t                    slot_q [lbp3_pkg::FIFO_DEPTH];
  logic [lbp3_pkg::FIFO_PTR_BITS-1:0]     wr_ptr_q, rd_ptr_q;
  logic [lbp3_pkg::FIFO_CNT_BITS-1:0]     count_q;
  logic                                   do_pop;

  assign valid_o = (count_q != '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({push_i, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  // Upstream credit keeps the queue from overflowing.
  `LBP3_ASSERT_IMP(a_fifo_no_overflow,
    push_i && !do_pop, count_q < lbp3_pkg::FIFO_CNT_BITS'(lbp3_pkg::FIFO_DEPTH))

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// LBP 3x3 unit testbench
// Streams raster frames and mapping table writes through the unit, works out
// each code as transactions are accepted and checks every result in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned MAX_W         = 4096;
  localparam int unsigned PIX_BITS      = 8;
  localparam int unsigned SETTLE_CYCLES = 16;    // pipeline plus result queue, with margin
  localparam int unsigned QUIET_LIMIT   = 2000;  // cycles without any transaction
  localparam int unsigned HOLD_CYCLES   = 300;   // long consumer hold-off
  localparam int unsigned PHASE_ITEMS   = 250;

  // 3x3 probe frame, first pixel in the low byte. Centre 0x80 sits between
  // 0x7F and 0x81, so unsigned and signed compares give different codes.
  localparam logic [71:0] PROBE_3X3 = {8'hFE, 8'h01, 8'h80, 8'h81, 8'h80,
                                       8'h7F, 8'h80, 8'hFF, 8'h00};

  typedef struct {
    lbp3_pkg::cmd_e cmd;
    logic [7:0]     pixel;
    logic [7:0]     index;
    logic [7:0]     value;
  } feed_item_t;

  typedef enum int { PIX_FULL, PIX_NARROW, PIX_CORNERS, PIX_FLAT } pixel_mix_e;

  logic                              clk_i = 1'b0;
  logic                              rst_ni;
  logic                              cfg_we;
  logic [lbp3_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [lbp3_pkg::DIM_BITS-1:0]     cfg_data;

  lbp3_in_if #(.PIXEL_BITS(PIX_BITS)) pix_ch ();
  lbp3_out_if                         code_ch ();

  local_binary_pattern_3x3_unit #(
    .MAX_WIDTH (MAX_W),
    .PIXEL_BITS(PIX_BITS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_i       (pix_ch),
    .out_o      (code_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: a copy of the unit's line stores, window, raster
  // position, mapping table and registers. Line stores and table start at
  // zero here; the stimulus never lets the unit read an unwritten entry.
  // --------------------------------------------------------------------------
  logic [7:0]                    upper_line  [MAX_W];
  logic [7:0]                    middle_line [MAX_W];
  logic [7:0]                    win [6];  // [0..2] column c-2 top to bottom, [3..5] c-1
  logic [7:0]                    code_map [256];
  int unsigned                   col_pos;
  int unsigned                   row_pos;
  logic [lbp3_pkg::DIM_BITS-1:0] width_reg;
  logic [lbp3_pkg::DIM_BITS-1:0] height_reg;
  bit                            uniform_reg;
  bit                            signed_reg;

  lbp3_pkg::out_item_t expected_codes [$];
  feed_item_t          pixel_feed [$];
  int unsigned         fed_count;
  int unsigned         mismatches;
  int unsigned         quiet_cycles;
  int unsigned         send_idle_pct;
  int unsigned         recv_idle_pct;
  bit                  in_taken;
  bit                  hold_req;
  int unsigned         hold_left;

  function automatic int unsigned clamp_dim(logic [lbp3_pkg::DIM_BITS-1:0] v,
                                            int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit at_or_above(logic [7:0] n, logic [7:0] c);
    if (signed_reg) return $signed(n) >= $signed(c);
    return n >= c;
  endfunction

  // One pixel transaction: advance the raster position and queue the code
  // when the window centre is an interior pixel.
  task automatic predict_code(logic [7:0] px);
    int unsigned         w, h, c, r;
    bit                  last_col, last_row;
    logic [7:0]          up, mid, pat;
    lbp3_pkg::out_item_t item;
    w = clamp_dim(width_reg, MAX_W);
    h = clamp_dim(height_reg, lbp3_pkg::MAX_HEIGHT);
    c = col_pos;
    r = row_pos;
    // a geometry shrink mid-frame pins the position to the new last column/row
    last_col = (c >= w - 1);
    last_row = (r >= h - 1);
    if (last_col) c = w - 1;
    if (last_row) r = h - 1;
    up  = upper_line[c];
    mid = middle_line[c];
    upper_line[c]  = mid;
    middle_line[c] = px;
    if (r >= 2 && c >= 2) begin
      pat = {at_or_above(win[0], win[4]), at_or_above(win[3], win[4]),
             at_or_above(up, win[4]),     at_or_above(mid, win[4]),
             at_or_above(px, win[4]),     at_or_above(win[5], win[4]),
             at_or_above(win[2], win[4]), at_or_above(win[1], win[4])};
      if (uniform_reg) pat = code_map[pat];
      item.code       = pat;
      item.frame_last = last_col && last_row;
      expected_codes.push_back(item);
    end
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = up;
    win[4] = mid;
    win[5] = px;
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  // Pixels still needed to close the current frame; valid only when idle.
  function automatic int unsigned pixels_to_frame_end();
    int unsigned w, h, c, r;
    w = clamp_dim(width_reg, MAX_W);
    h = clamp_dim(height_reg, lbp3_pkg::MAX_HEIGHT);
    c = (col_pos >= w - 1) ? w - 1 : col_pos;
    r = (row_pos >= h - 1) ? h - 1 : row_pos;
    return (h - 1 - r) * w + (w - 1 - c) + 1;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_pixel(logic [7:0] px);
    feed_item_t it;
    it.cmd   = lbp3_pkg::CMD_PIXEL;
    it.pixel = px;
    it.index = 8'($urandom);  // unused fields carry noise
    it.value = 8'($urandom);
    pixel_feed.push_back(it);
    fed_count++;
  endtask

  task automatic push_table(logic [7:0] idx, logic [7:0] val);
    feed_item_t it;
    it.cmd   = lbp3_pkg::CMD_TABLE;
    it.pixel = 8'($urandom);
    it.index = idx;
    it.value = val;
    pixel_feed.push_back(it);
    fed_count++;
  endtask

  // Pixel content styles: full range, near-equal values (ties exercise the
  // >= compare), sign-boundary corners, and flat areas.
  function automatic logic [7:0] pick_pixel(pixel_mix_e mix, logic [7:0] base);
    case (mix)
      PIX_NARROW: return base + 8'($urandom_range(3));
      PIX_CORNERS: begin
        case ($urandom_range(3))
          0:       return 8'h00;
          1:       return 8'h7F;
          2:       return 8'h80;
          default: return 8'hFF;
        endcase
      end
      PIX_FLAT: return base;
      default:  return 8'($urandom);
    endcase
  endfunction

  // Pixels with an occasional table write mixed in; table writes do not
  // move the raster position.
  task automatic queue_pixels(int unsigned count);
    pixel_mix_e mix;
    logic [7:0] base;
    mix  = pixel_mix_e'($urandom_range(3));
    base = 8'($urandom);
    for (int unsigned k = 0; k < count; k++) begin
      if ($urandom_range(99) < 4) push_table(8'($urandom), 8'($urandom));
      push_pixel(pick_pixel(mix, base));
    end
  endtask

  task automatic write_reg(lbp3_pkg::cfg_reg_e idx, int unsigned val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[lbp3_pkg::DIM_BITS-1:0];
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      lbp3_pkg::REG_FRAME_WIDTH:    width_reg   = val[lbp3_pkg::DIM_BITS-1:0];
      lbp3_pkg::REG_FRAME_HEIGHT:   height_reg  = val[lbp3_pkg::DIM_BITS-1:0];
      lbp3_pkg::REG_UNIFORM_ENABLE: uniform_reg = val[0];
      default:                      signed_reg  = val[0];
    endcase
  endtask

  // Everything sent, accepted and answered, then let the pipeline settle
  // since table writes and border pixels leave no result to wait for.
  task automatic wait_quiet();
    while (pixel_feed.size() != 0 || pix_ch.valid || expected_codes.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // New small geometry and modes; width and height sometimes below range.
  task automatic retune();
    wait_quiet();
    write_reg(lbp3_pkg::REG_FRAME_WIDTH,
              ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 12));
    write_reg(lbp3_pkg::REG_FRAME_HEIGHT,
              ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 8));
    write_reg(lbp3_pkg::REG_UNIFORM_ENABLE, $urandom_range(1));
    write_reg(lbp3_pkg::REG_SIGNED_COMPARE, $urandom_range(1));
  endtask

  // Whole frames back to back, retuned now and then between frames.
  task automatic run_phase(int unsigned snd_pct, int unsigned rcv_pct);
    int unsigned start;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    start = fed_count;
    while (fed_count - start < PHASE_ITEMS) begin
      if ($urandom_range(2) == 0) retune();
      queue_pixels(clamp_dim(width_reg, MAX_W) *
                   clamp_dim(height_reg, lbp3_pkg::MAX_HEIGHT));
    end
    wait_quiet();
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers the next pending transaction at the falling edge, keeps
  // it steady until accepted, and idles at random between transactions.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    feed_item_t nxt;
    if (!pix_ch.valid || in_taken) begin
      if (pixel_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pixel_feed.pop_front();
        pix_ch.valid       <= 1'b1;
        pix_ch.cmd         <= nxt.cmd;
        pix_ch.pixel       <= nxt.pixel;
        pix_ch.table_index <= nxt.index;
        pix_ch.table_value <= nxt.value;
      end else begin
        pix_ch.valid <= 1'b0;
      end
    end
    in_taken = 1'b0;
  end

  // Consumer ready: random stalls, or a long hold-off counted here so the
  // unit fills its result queue and has to stop taking input.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      code_ch.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
      code_ch.ready <= 1'b0;
    end else begin
      code_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: at the rising edge, feed accepted input transactions to the
  // predictor first, then compare any accepted result with the oldest
  // expected code. Also the watchdog on handshake activity.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    lbp3_pkg::out_item_t want;
    bit                  moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (pix_ch.valid && pix_ch.ready) begin
        moved    = 1'b1;
        in_taken = 1'b1;
        if (pix_ch.cmd == lbp3_pkg::CMD_TABLE) begin
          code_map[pix_ch.table_index] = pix_ch.table_value;
        end else begin
          predict_code(pix_ch.pixel);
        end
      end
      if (code_ch.valid && code_ch.ready) begin
        moved = 1'b1;
        if (expected_codes.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, code %02h frame_last %0b",
                   $time, code_ch.code, code_ch.frame_last);
        end else begin
          want = expected_codes.pop_front();
          if (code_ch.code !== want.code) begin
            mismatches++;
            $display("%0t: code mismatch, expected %02h, actual %02h",
                     $time, want.code, code_ch.code);
          end
          if (code_ch.frame_last !== want.frame_last) begin
            mismatches++;
            $display("%0t: frame_last mismatch, expected %0b, actual %0b",
                     $time, want.frame_last, code_ch.frame_last);
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = lbp3_pkg::REG_FRAME_WIDTH;
    cfg_data           = '0;
    pix_ch.valid       = 1'b0;
    pix_ch.cmd         = lbp3_pkg::CMD_PIXEL;
    pix_ch.pixel       = '0;
    pix_ch.table_index = '0;
    pix_ch.table_value = '0;
    code_ch.ready      = 1'b0;

    width_reg   = lbp3_pkg::WIDTH_RESET;
    height_reg  = lbp3_pkg::HEIGHT_RESET;
    uniform_reg = 1'b0;
    signed_reg  = 1'b0;
    col_pos     = 0;
    row_pos     = 0;
    for (int k = 0; k < 6; k++) win[k] = '0;
    for (int k = 0; k < MAX_W; k++) begin
      upper_line[k]  = '0;
      middle_line[k] = '0;
    end
    for (int k = 0; k < 256; k++) code_map[k] = '0;
    fed_count     = 0;
    mismatches    = 0;
    quiet_cycles  = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    in_taken      = 1'b0;
    hold_req      = 1'b0;
    hold_left     = 0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: below-range geometry saturates to 3x3, table writes at both
    // ends of index and value (one inside the frame), then the probe frame
    // with unsigned and with signed compare.
    write_reg(lbp3_pkg::REG_FRAME_WIDTH, 2);
    write_reg(lbp3_pkg::REG_FRAME_HEIGHT, 0);
    push_table(8'h00, 8'hFF);
    for (int k = 0; k < 9; k++) begin
      push_pixel(PROBE_3X3[8*k +: 8]);
      if (k == 3) push_table(8'hFF, 8'h00);
    end
    wait_quiet();
    write_reg(lbp3_pkg::REG_SIGNED_COMPARE, 1);
    for (int k = 0; k < 9; k++) push_pixel(PROBE_3X3[8*k +: 8]);

    // Load the whole mapping table before uniform mode can be switched on.
    for (int k = 0; k < 256; k++) push_table(8'(k), 8'($urandom));

    run_phase(14, 88);
    run_phase(88, 14);

    // No idling; a queue of frames is waiting while the consumer holds off.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    retune();
    for (int k = 0; k < 3; k++)
      queue_pixels(clamp_dim(width_reg, MAX_W) *
                   clamp_dim(height_reg, lbp3_pkg::MAX_HEIGHT));
    hold_req = 1'b1;
    run_phase(0, 0);

    // Above-range width saturates to the line store size: a short start of
    // row 0, then a narrower width pins the column to its new last column.
    write_reg(lbp3_pkg::REG_UNIFORM_ENABLE, 1);
    write_reg(lbp3_pkg::REG_SIGNED_COMPARE, 0);
    write_reg(lbp3_pkg::REG_FRAME_WIDTH, 8191);
    write_reg(lbp3_pkg::REG_FRAME_HEIGHT, 3);
    queue_pixels(24);
    wait_quiet();
    write_reg(lbp3_pkg::REG_FRAME_WIDTH, 6);
    queue_pixels(pixels_to_frame_end());
    wait_quiet();

    // Tallest height, cut short mid-frame: the row is pinned to the new last row.
    write_reg(lbp3_pkg::REG_UNIFORM_ENABLE, 0);
    write_reg(lbp3_pkg::REG_FRAME_WIDTH, 5);
    write_reg(lbp3_pkg::REG_FRAME_HEIGHT, 8191);
    queue_pixels(60);
    wait_quiet();
    write_reg(lbp3_pkg::REG_FRAME_HEIGHT, 4);
    queue_pixels(pixels_to_frame_end());
    wait_quiet();

    // Width shrunk mid-row past the current column: that column becomes last.
    write_reg(lbp3_pkg::REG_FRAME_WIDTH, 16);
    write_reg(lbp3_pkg::REG_FRAME_HEIGHT, 6);
    queue_pixels(40);
    wait_quiet();
    write_reg(lbp3_pkg::REG_FRAME_WIDTH, 5);
    queue_pixels(pixels_to_frame_end());
    wait_quiet();

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/lbp3_pkg.sv
src/lbp3_channels.sv
src/lbp3_ram.sv
src/lbp3_window.sv
src/lbp3_out_fifo.sv
src/local_binary_pattern_3x3_unit.sv
tb/sv/tb.sv
